### src/bclru_pkg.sv
// package for the block cache lru tag controller
// holds transaction structs, operation and status codes, defaults
package bclru_pkg;

   localparam int SlotCountDefault = 64;
   localparam int NodeBitsDefault  = 16;
   localparam int BlockBitsDefault = 32;
   localparam int StampBits        = 64;

   typedef enum logic [2:0] {
      OP_LOOKUP    = 3'd0,
      OP_PREFETCH  = 3'd1,
      OP_FILL_DONE = 3'd2,
      OP_INV_RANGE = 3'd3,
      OP_INV_DEV   = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_HIT     = 3'd0,
      ST_MISS    = 3'd1,
      ST_BUSY    = 3'd2,
      ST_DONE    = 3'd3,
      ST_PRESENT = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] node_id;
      logic [31:0] block_index;
      logic [31:0] range_end;
      logic [5:0]  fill_slot;
      logic        fill_ok;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] slot;
      logic       need_fill;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // register the request and run the search
      logic apply;     // commit state update and emit response
   } cmd_type;

endpackage

### src/bclru_ctrl.sv
// controller state machine for the block cache lru tag controller
// depends on bclru_pkg
module bclru_ctrl import bclru_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output cmd_type cmd
);

   typedef enum logic [0:0] {S_IDLE, S_APPLY} state_type;

   state_type state_ff;

   // search on capture in idle, then commit in the apply state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE:  if (start) state_ff <= S_APPLY;
            S_APPLY: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy        = (state_ff == S_APPLY);
   assign cmd.capture = (state_ff == S_IDLE) && start;
   assign cmd.apply   = (state_ff == S_APPLY);

   a_apply_after_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.apply) else $error("apply did not follow capture");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.apply)) else $error("capture during apply");
   a_apply_once: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> !cmd.apply) else $error("apply held two cycles");

endmodule

### src/bclru_datapath.sv
// tag store, stamps and victim search for the block cache lru tag controller
// depends on bclru_pkg
module bclru_datapath import bclru_pkg::*; #(
   parameter int SLOT_COUNT = SlotCountDefault,
   parameter int NODE_BITS  = NodeBitsDefault,
   parameter int BLOCK_BITS = BlockBitsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req,
   output logic    rsp_strobe,
   output rsp_type rsp
);

   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int BW = (BLOCK_BITS < 32) ? BLOCK_BITS : 32;
   localparam int NW = (NODE_BITS < 16) ? NODE_BITS : 16;

   logic [NW-1:0]        tag_node_ff  [SLOT_COUNT];
   logic [BW-1:0]        tag_block_ff [SLOT_COUNT];
   logic [StampBits-1:0] stamp_ff     [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] valid_ff, loading_ff;
   logic [StampBits-1:0] clock_ff;

   // captured request and search outcome
   logic [2:0]           op_ff;
   logic [NW-1:0]        node_ff;
   logic [BW-1:0]        block_ff;
   logic [SLOT_COUNT-1:0] match_ff;
   logic [5:0]           fslot_ff;
   logic                 fok_ff;
   logic                 vhit_ff, lhit_ff, vic_ok_ff;
   logic [SW-1:0]        vslot_ff, lslot_ff, vic_ff;

   logic [NW-1:0]        node_in;
   logic [BW-1:0]        block_in, last_in;
   logic [SLOT_COUNT-1:0] nmatch, vmatch, lmatch, rmatch, idle, empty;

   assign node_in  = req.node_id[NW-1:0];
   assign block_in = req.block_index[BW-1:0];
   assign last_in  = req.range_end[BW-1:0];

   // parallel tag compare
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         nmatch[i] = tag_node_ff[i] == node_in;
         vmatch[i] = valid_ff[i] && nmatch[i] && tag_block_ff[i] == block_in;
         lmatch[i] = loading_ff[i] && nmatch[i] && tag_block_ff[i] == block_in;
         rmatch[i] = valid_ff[i] && nmatch[i] &&
                     (req.operation == OP_INV_DEV ||
                      (tag_block_ff[i] >= block_in && tag_block_ff[i] <= last_in));
         idle[i]   = !loading_ff[i];
         empty[i]  = idle[i] && !valid_ff[i];
      end
   end

   // lowest index priority encoders
   logic          vhit, lhit, ehit;
   logic [SW-1:0] vslot, lslot, eslot;
   always_comb begin
      vhit = 1'b0; lhit = 1'b0; ehit = 1'b0;
      vslot = '0; lslot = '0; eslot = '0;
      for (int i = SLOT_COUNT-1; i >= 0; i--) begin
         if (vmatch[i]) begin vhit = 1'b1; vslot = SW'(i); end
         if (lmatch[i]) begin lhit = 1'b1; lslot = SW'(i); end
         if (empty[i])  begin ehit = 1'b1; eslot = SW'(i); end
      end
   end

   // lru minimum tree over idle slots, ties to lower index
   localparam int LV = SW;
   localparam int NP = 1 << LV;
   logic             tv  [2*NP];
   logic [StampBits-1:0] ts [2*NP];
   logic [SW-1:0]    ti  [2*NP];
   always_comb begin
      for (int i = 0; i < NP; i++) begin
         if (i < SLOT_COUNT) begin
            tv[NP+i] = idle[i]; ts[NP+i] = stamp_ff[i];
         end else begin
            tv[NP+i] = 1'b0; ts[NP+i] = '0;
         end
         ti[NP+i] = SW'(i);
      end
      for (int n = NP-1; n >= 1; n--) begin
         if (tv[2*n] && (!tv[2*n+1] || ts[2*n] <= ts[2*n+1])) begin
            tv[n] = tv[2*n]; ts[n] = ts[2*n]; ti[n] = ti[2*n];
         end else begin
            tv[n] = tv[2*n+1]; ts[n] = ts[2*n+1]; ti[n] = ti[2*n+1];
         end
      end
      tv[0] = 1'b0; ts[0] = '0; ti[0] = '0;
   end

   // capture search result
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req.operation;
         node_ff   <= node_in;
         block_ff  <= block_in;
         match_ff  <= rmatch;
         fslot_ff  <= req.fill_slot;
         fok_ff    <= req.fill_ok;
         vhit_ff   <= vhit;
         lhit_ff   <= lhit;
         vslot_ff  <= vslot;
         lslot_ff  <= lslot;
         vic_ok_ff <= tv[1];
         vic_ff    <= ehit ? eslot : ti[1];
      end
   end

   logic fvalid;
   logic [SW-1:0] fidx;
   assign fvalid = (32'(fslot_ff) < SLOT_COUNT);
   assign fidx   = SW'(fslot_ff);

   // response for the captured transaction
   rsp_type rsp_in;
   always_comb begin
      rsp_in        = '0;
      rsp_in.status = ST_DONE;
      unique case (op_ff)
         OP_LOOKUP, OP_PREFETCH: begin
            if (vhit_ff) begin
               rsp_in.slot   = 6'(vslot_ff);
               rsp_in.status = (op_ff == OP_LOOKUP) ? ST_HIT : ST_PRESENT;
            end else if (lhit_ff) begin
               rsp_in.slot   = 6'(lslot_ff);
               rsp_in.status = (op_ff == OP_LOOKUP) ? ST_BUSY : ST_PRESENT;
            end else if (!vic_ok_ff) begin
               rsp_in.status = ST_BUSY;
            end else begin
               rsp_in.status    = ST_MISS;
               rsp_in.slot      = 6'(vic_ff);
               rsp_in.need_fill = 1'b1;
            end
         end
         OP_FILL_DONE: rsp_in.slot = fslot_ff;
         default: ;
      endcase
   end

   // commit and respond
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         loading_ff <= '0;
         clock_ff   <= '0;
         rsp_strobe <= 1'b0;
         rsp        <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            tag_node_ff[i]  <= '0;
            tag_block_ff[i] <= '0;
            stamp_ff[i]     <= '0;
         end
      end else begin
         rsp_strobe <= cmd.apply;
         if (cmd.apply) begin
            rsp <= rsp_in;
            unique case (op_ff)
               OP_LOOKUP, OP_PREFETCH: begin
                  if (vhit_ff) begin
                     if (op_ff == OP_LOOKUP) begin
                        clock_ff <= clock_ff + 1'b1;
                        stamp_ff[vslot_ff] <= clock_ff + 1'b1;
                     end
                  end else if (!lhit_ff && vic_ok_ff) begin
                     valid_ff[vic_ff]     <= 1'b0;
                     loading_ff[vic_ff]   <= 1'b1;
                     tag_node_ff[vic_ff]  <= node_ff;
                     tag_block_ff[vic_ff] <= block_ff;
                  end
               end
               OP_FILL_DONE: begin
                  if (fvalid && loading_ff[fidx]) begin
                     loading_ff[fidx] <= 1'b0;
                     valid_ff[fidx]   <= fok_ff;
                     if (fok_ff) begin
                        clock_ff <= clock_ff + 1'b1;
                        stamp_ff[fidx] <= clock_ff + 1'b1;
                     end
                  end
               end
               OP_INV_RANGE, OP_INV_DEV: valid_ff <= valid_ff & ~match_ff;
               default: ;
            endcase
         end
      end
   end

   a_no_valid_loading: assert property (@(posedge clock) disable iff (reset)
      (valid_ff & loading_ff) == '0) else $error("slot valid and loading");
   a_fill_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp.need_fill == (rsp.status == ST_MISS)))
      else $error("need_fill mismatch");
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> rsp_strobe) else $error("missing response");

endmodule

### src/block_cache_lru_tag_controller_unit.sv
// top level of the block cache lru tag controller
// each transaction: accepted at start, then apply state, then registered strobe
// no new transaction is accepted during the apply state; search then commit
// busy high for the cycle after accept; responses cannot be stalled
// synchronous reset empties every slot and zeroes the use clock
module block_cache_lru_tag_controller_unit import bclru_pkg::*; #(
   parameter int SLOT_COUNT = SlotCountDefault,
   parameter int NODE_BITS  = NodeBitsDefault,
   parameter int BLOCK_BITS = BlockBitsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   cmd_type cmd;

   bclru_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .cmd
   );

   bclru_datapath #(
      .SLOT_COUNT(SLOT_COUNT), .NODE_BITS(NODE_BITS), .BLOCK_BITS(BLOCK_BITS)
   ) u_dp (
      .clock, .reset, .cmd, .req(req_data), .rsp_strobe, .rsp(rsp_data)
   );

endmodule

### tb/tb_block_cache_lru_tag_controller_unit.sv
// testbench for the block cache lru tag controller unit
// depends on bclru_pkg and the block top level; predicts each response in a scoreboard class
module tb_block_cache_lru_tag_controller_unit;
   import bclru_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 64;
   localparam int CYCLE_LIMIT = 200000;

   // expected responses and a model of the tag store
   class tag_store_scoreboard;
      logic [15:0] node_tag [NSLOT];
      logic [31:0] block_tag [NSLOT];
      logic [63:0] stamp [NSLOT];
      bit          valid [NSLOT];
      bit          loading [NSLOT];
      logic [63:0] use_clock;
      rsp_type     pending [$];
      int          errors;

      function void clear();
         for (int i = 0; i < NSLOT; i++) begin
            node_tag[i] = '0; block_tag[i] = '0; stamp[i] = '0;
            valid[i] = 0; loading[i] = 0;
         end
         use_clock = '0;
         errors = 0;
         pending.delete();
      endfunction

      function int find_tag(logic [15:0] n, logic [31:0] b, bit want_loading);
         for (int i = 0; i < NSLOT; i++)
            if ((want_loading ? loading[i] : valid[i]) && node_tag[i] == n
                && block_tag[i] == b)
               return i;
         return -1;
      endfunction

      function int pick_victim();
         int best;
         best = -1;
         for (int i = 0; i < NSLOT; i++) begin
            if (loading[i]) continue;
            if (!valid[i]) return i;
            if (best < 0 || stamp[i] < stamp[best]) best = i;
         end
         return best;
      endfunction

      // predict the response of one accepted transaction
      function void note_request(req_type r);
         rsp_type e;
         int s;
         e = '0;
         e.status = ST_DONE;
         case (r.operation)
            OP_LOOKUP, OP_PREFETCH: begin
               s = find_tag(r.node_id, r.block_index, 0);
               if (s >= 0) begin
                  e.slot = 6'(s);
                  if (r.operation == OP_LOOKUP) begin
                     use_clock++;
                     stamp[s] = use_clock;
                     e.status = ST_HIT;
                  end else e.status = ST_PRESENT;
               end else begin
                  s = find_tag(r.node_id, r.block_index, 1);
                  if (s >= 0) begin
                     e.slot = 6'(s);
                     e.status = (r.operation == OP_LOOKUP) ? ST_BUSY : ST_PRESENT;
                  end else begin
                     s = pick_victim();
                     if (s < 0) e.status = ST_BUSY;
                     else begin
                        valid[s] = 0; loading[s] = 1;
                        node_tag[s] = r.node_id; block_tag[s] = r.block_index;
                        e.status = ST_MISS; e.slot = 6'(s); e.need_fill = 1'b1;
                     end
                  end
               end
            end
            OP_FILL_DONE: begin
               if (loading[r.fill_slot]) begin
                  loading[r.fill_slot] = 0;
                  valid[r.fill_slot] = r.fill_ok;
                  if (r.fill_ok) begin
                     use_clock++;
                     stamp[r.fill_slot] = use_clock;
                  end
               end
               e.slot = r.fill_slot;
            end
            OP_INV_RANGE, OP_INV_DEV: begin
               for (int i = 0; i < NSLOT; i++)
                  if (valid[i] && node_tag[i] == r.node_id &&
                      (r.operation == OP_INV_DEV ||
                       (block_tag[i] >= r.block_index && block_tag[i] <= r.range_end)))
                     valid[i] = 0;
            end
            default: ;
         endcase
         pending.push_back(e);
      endfunction

      task check_response(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected response %p", got));
            return;
         end
         e = pending.pop_front();
         if (got.status !== e.status)
            report_mismatch($sformatf("status %0d exp %0d", got.status, e.status));
         if (got.slot !== e.slot)
            report_mismatch($sformatf("slot %0d exp %0d", got.slot, e.slot));
         if (got.need_fill !== e.need_fill)
            report_mismatch($sformatf("need_fill %0d exp %0d", got.need_fill, e.need_fill));
      endtask

      task report_mismatch(string msg);
         errors++;
         if (errors <= 50) $display("mismatch: %s", msg);
      endtask
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   tag_store_scoreboard sb;
   int idle_pct;
   int cycles;
   logic [15:0] hot_nodes [4];
   logic [31:0] hot_blocks [8];
   int loading_slots [$];

   block_cache_lru_tag_controller_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // response checking and cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_strobe) sb.check_response(rsp_data);
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // send one transaction, honoring busy and random sender gaps
   task automatic send_request(req_type r);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      if (r.operation inside {OP_LOOKUP, OP_PREFETCH} && sb.pending[$].status == ST_MISS)
         loading_slots.push_back(sb.pending[$].slot);
   endtask

   task automatic send_op(logic [2:0] op, logic [15:0] n, logic [31:0] b, logic [31:0] l,
                          logic [5:0] fs, logic ok);
      req_type r;
      r.operation = op; r.node_id = n; r.block_index = b; r.range_end = l;
      r.fill_slot = fs; r.fill_ok = ok;
      send_request(r);
   endtask

   // well formed traffic over a small tag set, with some noise
   task automatic random_request();
      req_type r;
      logic [95:0] noise;
      int k;
      noise = {$urandom, $urandom, $urandom};
      r = noise[$bits(req_type)-1:0];
      k = $urandom_range(99);
      r.node_id = hot_nodes[$urandom_range(3)];
      r.block_index = hot_blocks[$urandom_range(7)] + $urandom_range(15);
      if (k < 40) r.operation = OP_LOOKUP;
      else if (k < 52) r.operation = OP_PREFETCH;
      else if (k < 80) begin
         r.operation = OP_FILL_DONE;
         if (loading_slots.size() > 0 && $urandom_range(9) < 8) begin
            int idx;
            idx = $urandom_range(loading_slots.size() - 1);
            r.fill_slot = 6'(loading_slots[idx]);
            loading_slots.delete(idx);
            r.fill_ok = ($urandom_range(9) < 8);
         end
      end else if (k < 88) begin
         r.operation = OP_INV_RANGE;
         r.range_end = r.block_index + $urandom_range(20) - 4;
      end else if (k < 92) r.operation = OP_INV_DEV;
      else if (k >= 97) r.operation = 3'(5 + $urandom_range(2));
      else begin
         noise = {$urandom, $urandom, $urandom};
         r = noise[$bits(req_type)-1:0];
      end
      send_request(r);
   endtask

   initial begin
      sb = new();
      sb.clear();
      cycles = 0;
      idle_pct = 0;
      hot_nodes = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8000};
      hot_blocks = '{32'h0, 32'hFFFF_FFF0, 32'h100, 32'h8000_0000,
                     32'h7FFF_FFF8, 32'h5555_5550, 32'hAAAA_AAA0, 32'h1000};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every operation, special cases
      send_op(OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0);      // miss, slot 0
      send_op(OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0);      // loading: busy
      send_op(OP_PREFETCH, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0);    // loading: present
      send_op(OP_FILL_DONE, 0, 0, 0, 6'd0, 1);                   // fill ok
      send_op(OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0);      // hit
      send_op(OP_PREFETCH, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0);    // present
      send_op(OP_FILL_DONE, 0, 0, 0, 6'd63, 1);                  // stray fill done
      send_op(OP_PREFETCH, 16'h0000, 32'h0, 0, 0, 0);            // miss slot 1
      send_op(OP_FILL_DONE, 0, 0, 0, 6'd1, 0);                   // failed fill
      send_op(OP_INV_RANGE, 16'hFFFF, 32'h5, 32'h4, 0, 0);       // empty range
      send_op(OP_INV_RANGE, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 0, 0);
      send_op(OP_INV_DEV, 16'hFFFF, 0, 0, 0, 0);
      send_op(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1);
      loading_slots.delete();
      // fill every slot with loads, then one more is busy, then free them
      for (int i = 0; i < NSLOT; i++) send_op(OP_LOOKUP, 16'h0042, i, 0, 0, 0);
      send_op(OP_LOOKUP, 16'h0043, 32'h9, 0, 0, 0);
      send_op(OP_PREFETCH, 16'h0043, 32'h9, 0, 0, 0);
      for (int i = 0; i < NSLOT; i++) send_op(OP_FILL_DONE, 0, 0, 0, 6'(i), 1);
      send_op(OP_LOOKUP, 16'h0042, 32'd5, 0, 0, 0);
      send_op(OP_LOOKUP, 16'h0043, 32'h9, 0, 0, 0);              // lru victim
      loading_slots.delete();
      loading_slots.push_back(sb.pending[$].slot);

      // random phases with varying sender gaps
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 51 : (ph == 3) ? 30 : 0;
         for (int n = 0; n < 100; n++) random_request();
      end
      start <= 0;

      // drain
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

### filelist.f
src/bclru_pkg.sv
src/bclru_ctrl.sv
src/bclru_datapath.sv
src/block_cache_lru_tag_controller_unit.sv
tb/tb_block_cache_lru_tag_controller_unit.sv
